// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; compiled first.
package spq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic  shift_in;   // insert value at its sorted place
    logic  shift_out;  // drop the head, advance everything towards it
    data_t value;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the queue's request and result sides.
// Depends on spq_pkg.
interface spq_in_if
  import spq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic signed [DataW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] removed_value;
  logic signed [DataW-1:0] max_value;
  logic                    is_empty;
  logic [CountW-1:0]       entry_count;

  modport source (output valid, output status, output removed_value, output max_value,
                  output is_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input max_value,
                  input is_empty, input entry_count, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the new value.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       slot_valid,
  input  logic       left_keep,
  input  data_t      left_entry,
  input  data_t      right_entry,
  output logic       keep,
  output data_t      entry_next,
  output data_t      entry
);

  // Hold when the stored value is strictly larger: equal values go behind the new one.
  assign keep = slot_valid && (entry > ctrl.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_in) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = ctrl.value;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.shift_out) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted max priority queue: a chain of CAPACITY compare-and-shift cells.
// Result: registered at the request transfer and presented in the cycle after it.
// Throughput: one request per cycle while the result side is ready; every cell updates in parallel each cycle.
// Reset (rst, synchronous): count and output valid cleared; entries keep junk.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // Occupancy; slots at or above it hold stale data and are never reported.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  data_t entry      [CAPACITY];
  data_t entry_next [CAPACITY];
  logic  keep       [CAPACITY];

  cell_ctrl_t ctrl;
  logic       accept;
  action_t    act;
  status_t    status_next;
  data_t      removed_next;

  // Output register parts the two sides: take a new request while the
  // previous result is being transferred.
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = action_t'(in_ch.action);

  // Decode the request; refused inserts and empty deletes leave the chain alone.
  always_comb begin
    ctrl.shift_in  = 1'b0;
    ctrl.shift_out = 1'b0;
    ctrl.value     = in_ch.value;
    count_next     = count;
    status_next    = ST_OK;
    removed_next   = '0;
    case (act)
      ACT_INSERT: begin
        if (count >= CapCount) begin
          status_next = ST_FULL;
        end else begin
          ctrl.shift_in = accept;
          count_next    = count + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.shift_out = accept;
          count_next     = count - 1'b1;
          removed_next   = entry[0];
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // The chain: each cell sees its neighbours' entries and the keep flag ahead of it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic  left_keep;
    data_t left_entry;
    data_t right_entry;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (Idx < count),
      .left_keep  (left_keep),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .keep       (keep[i]),
      .entry_next (entry_next[i]),
      .entry      (entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        count        <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Result payload: report the queue as it stands after this step.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.status        <= status_next;
      out_ch.removed_value <= removed_next;
      out_ch.max_value     <= (count_next != '0) ? entry_next[0] : '0;
      out_ch.is_empty      <= (count_next == '0);
      out_ch.entry_count   <= CountW'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CapCount)
    else $error("occupancy above capacity");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (entry[0] >= entry[1]))
    else $error("head entries out of order");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_empty) |-> (out_ch.max_value == '0))
    else $error("empty result reports a maximum");

  a_removed_zero : assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != ST_OK) |=> (out_ch.removed_value == '0))
    else $error("failed request reports a removed value");
`endif

endmodule
